FILE: rtl/ept_pkg.sv
// ============================================================================
// ept_pkg
// Shared constants and types for the edge-period tachometer.
// ============================================================================
package ept_pkg;

  // Depth of the stamp ring unless the top level is told otherwise.
  localparam int MAX_TRIGGERS_DEF = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_US    = 1'b1;
  localparam int CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [4:0]  TRIGGER_COUNT_RST = 5'd2;
  localparam logic [31:0] TIMEOUT_US_RST    = 32'd1000000;

  // Item kinds.
  localparam logic KIND_EDGE  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Speed arithmetic: the speed in rpm is this numerator over the span in microseconds.
  localparam logic [31:0] RPM_NUMERATOR = 32'd120000000;
  localparam int          NUM_W         = 27;
  localparam logic [15:0] SPEED_MAX     = 16'hFFFF;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // One classified query waiting for the divider.
  typedef struct packed {
    logic        stalled;
    logic [31:0] span;
  } query_t;

endpackage

FILE: rtl/ept_if.sv
// ============================================================================
// ept_in_if / ept_out_if
// Valid/ready channels for input words and result words.
// ============================================================================
interface ept_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] now_us;

  modport source (output valid, output kind, output now_us, input ready);
  modport sink   (input valid, input kind, input now_us, output ready);
endinterface

interface ept_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_rpm;
  logic        stalled;

  modport source (output valid, output speed_rpm, output stalled, input ready);
  modport sink   (input valid, input speed_rpm, input stalled, output ready);
endinterface

FILE: rtl/ept_front.sv
// ============================================================================
// ept_front
// Accepts words, updates the stamp ring on edges and classifies queries.
// ============================================================================
module ept_front #(
  parameter int MAX_TRIGGERS = ept_pkg::MAX_TRIGGERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ept_in_if.sink               in_ch,
  input  logic [4:0]           trigger_count,
  input  logic [31:0]          timeout_us,
  input  logic                 queue_full,
  output logic                 push_valid,
  output ept_pkg::query_t      push_data
);

  localparam int PW = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
  localparam int LW = $clog2(MAX_TRIGGERS + 1);

  logic [31:0]       ring_r     [MAX_TRIGGERS];
  logic [MAX_TRIGGERS-1:0] ring_vld_r;
  logic [31:0]       latest_r;
  logic [PW-1:0]     pos_r;
  logic [PW-1:0]     pos_nxt;

  logic              accept;
  logic [31:0]       oldest;
  logic [31:0]       age;
  logic [LW-1:0]     wlen;
  logic [PW:0]       pos_inc;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Slots never written since reset read as zero.
  assign oldest = ring_vld_r[pos_r] ? ring_r[pos_r] : 32'd0;
  assign age    = in_ch.now_us - oldest;

  // Window length is the trigger count clamped to one through the ring depth.
  always_comb begin
    if (trigger_count == 5'd0) begin
      wlen = LW'(1);
    end else if (32'(trigger_count) > 32'(MAX_TRIGGERS)) begin
      wlen = LW'(MAX_TRIGGERS);
    end else begin
      wlen = LW'(trigger_count);
    end
  end

  assign pos_inc = {1'b0, pos_r} + (PW+1)'(1);
  assign pos_nxt = (32'(pos_inc) >= 32'(wlen)) ? '0 : pos_inc[PW-1:0];

  assign push_valid        = accept && (in_ch.kind == ept_pkg::KIND_QUERY);
  assign push_data.stalled = (age >= timeout_us);
  assign push_data.span    = latest_r - oldest;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      latest_r   <= '0;
      pos_r      <= '0;
    end else if (accept && (in_ch.kind == ept_pkg::KIND_EDGE)) begin
      ring_vld_r[pos_r] <= 1'b1;
      latest_r          <= in_ch.now_us;
      pos_r             <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_ch.kind == ept_pkg::KIND_EDGE)) begin
      ring_r[pos_r] <= latest_r;
    end
  end

endmodule

FILE: rtl/ept_queue.sv
// ============================================================================
// ept_queue
// Short queue of classified queries between the front and the back.
// ============================================================================
module ept_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ept_pkg::query_t  push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output ept_pkg::query_t  pop_data
);

  localparam int DEPTH = ept_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  ept_pkg::query_t entry_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full      = (32'(count_r) == 32'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/ept_back.sv
// ============================================================================
// ept_back
// Divides the rpm constant by the window span, one quotient bit per cycle.
// ============================================================================
module ept_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             not_empty,
  input  ept_pkg::query_t  pop_data,
  output logic             pop,
  ept_out_if.source        out_ch
);

  localparam int NW = ept_pkg::NUM_W;
  localparam int CW = $clog2(NW);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state_r;
  logic [1:0]    state_nxt;
  logic [CW-1:0] cnt_r;
  logic [31:0]   span_r;
  logic [31:0]   rem_r;
  logic [NW-1:0] quo_r;
  logic [15:0]   speed_r;
  logic          stalled_r;
  logic          out_valid_r;
  logic [15:0]   out_speed_r;
  logic          out_stalled_r;

  logic [32:0]   trial;
  logic [NW-1:0] quo_nxt;
  logic          out_free;

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = (state_r == ST_IDLE) && not_empty;

  // Restoring step: shift in the next numerator bit and try the subtraction.
  assign trial   = {rem_r, ept_pkg::RPM_NUMERATOR[cnt_r]} - {1'b0, span_r};
  assign quo_nxt = {quo_r[NW-2:0], !trial[32]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (not_empty) begin
          if (pop_data.stalled || (pop_data.span == 32'd0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        span_r    <= pop_data.span;
        rem_r     <= '0;
        quo_r     <= '0;
        cnt_r     <= CW'(NW - 1);
        stalled_r <= pop_data.stalled;
        speed_r   <= pop_data.stalled ? 16'd0 : ept_pkg::SPEED_MAX;
      end
      ST_DIV: begin
        rem_r <= trial[32] ? {rem_r[30:0], ept_pkg::RPM_NUMERATOR[cnt_r]} : trial[31:0];
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == '0) begin
          speed_r <= (quo_nxt > NW'(ept_pkg::SPEED_MAX)) ? ept_pkg::SPEED_MAX
                                                         : quo_nxt[15:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_speed_r   <= speed_r;
          out_stalled_r <= stalled_r;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.speed_rpm = out_speed_r;
  assign out_ch.stalled   = out_stalled_r;

endmodule

FILE: rtl/edge_period_tachometer.sv
// ============================================================================
// edge_period_tachometer
// Period-based tachometer: sensor edges fill a ring of stamps, speed queries
// return the rpm over the window or a stalled flag after a timeout.
// ============================================================================
//
//   channel  direction  payload                 handshake
//   -------  ---------  ----------------------  ----------------------------
//   in_ch    sink       kind, now_us            valid/ready
//   out_ch   source     speed_rpm, stalled      valid/ready
//   cfg_*    sink       cfg_index, cfg_wdata    cfg_we, no back-pressure
//
// An edge word yields no result. A query word is classified in the cycle
// it is accepted and queued; the back end then loads it, runs the
// restoring divider over the 27-bit numerator at one quotient bit per
// cycle and hands the word to the output register, or skips the division
// when the query is stalled or the span is zero.
// Reset is synchronous and active low; the ring reads as all zero after it.
// The input is stalled only while the query queue is full; the output
// register holds its word until out_ch.ready is seen.
//
module edge_period_tachometer #(
  parameter int MAX_TRIGGERS = ept_pkg::MAX_TRIGGERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ept_in_if.sink                            in_ch,
  ept_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [ept_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ept_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Cfg registers. Users write only while the block is idle; not enforced.
  logic [4:0]  trigger_count_r;
  logic [31:0] timeout_us_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_count_r <= ept_pkg::TRIGGER_COUNT_RST;
      timeout_us_r    <= ept_pkg::TIMEOUT_US_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ept_pkg::CFG_TRIGGER_COUNT: trigger_count_r <= cfg_wdata[4:0];
        ept_pkg::CFG_TIMEOUT_US:    timeout_us_r    <= cfg_wdata[31:0];
        default: begin
          trigger_count_r <= trigger_count_r;
        end
      endcase
    end
  end

  // Front end: takes words while the queue has room, updates the ring on
  // edges and snapshots the span and timeout check of each query into the
  // queue. Because the snapshot is taken at acceptance, later edges cannot
  // disturb a query that is still waiting for the divider.
  logic            push_valid;
  ept_pkg::query_t push_data;
  logic            queue_full;
  logic            pop;
  logic            not_empty;
  ept_pkg::query_t pop_data;

  ept_front #(
    .MAX_TRIGGERS (MAX_TRIGGERS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .trigger_count (trigger_count_r),
    .timeout_us    (timeout_us_r),
    .queue_full    (queue_full),
    .push_valid    (push_valid),
    .push_data     (push_data)
  );

  // Queue of classified queries, so edges keep flowing while the divider
  // is busy and the queue is not full.
  ept_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  // Back end: divider, saturation and the output register.
  ept_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .not_empty (not_empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: test/tachometer_checker.sv
// ============================================================================
// tachometer_checker
// Watches the word and configuration ports of the tachometer, predicts every
// speed reading from its own copy of the stamp ring and compares the readings
// that come out, in order, field by field.
// ============================================================================
module tachometer_checker #(
  parameter int MAX_TRIGGERS = ept_pkg::MAX_TRIGGERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ept_in_if                              in_mon,
  ept_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [ept_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ept_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             pending_readings,
  output int                             fail_count
);
  import ept_pkg::*;

  typedef struct packed {
    logic [15:0] speed_rpm;
    logic        stalled;
  } reading_t;

  logic [31:0] edge_stamps [MAX_TRIGGERS];
  logic [31:0] last_edge_us;
  int unsigned oldest_slot;
  logic [4:0]  trigger_reg;
  logic [31:0] timeout_reg;
  reading_t    readings_due [$];

  initial begin
    fail_count       = 0;
    pending_readings = 0;
  end

  // A trigger count of zero behaves as one, anything above the ring depth as
  // the full ring.
  function automatic int unsigned window_edges();
    int unsigned n;
    n = trigger_reg;
    if (n == 0) n = 1;
    if (n > MAX_TRIGGERS) n = MAX_TRIGGERS;
    return n;
  endfunction

  // Applies one accepted word to the ring and queues the reading it causes.
  task automatic apply_word(input logic word_kind, input logic [31:0] now_us);
    logic [31:0] oldest;
    logic [31:0] age;
    logic [31:0] span;
    logic [31:0] quotient;
    reading_t    reading;
    oldest = edge_stamps[oldest_slot];
    if (word_kind == KIND_EDGE) begin
      edge_stamps[oldest_slot] = last_edge_us;
      last_edge_us = now_us;
      oldest_slot++;
      if (oldest_slot >= window_edges()) oldest_slot = 0;
    end else begin
      age = now_us - oldest;
      if (age >= timeout_reg) begin
        reading.speed_rpm = '0;
        reading.stalled   = 1'b1;
      end else begin
        span = last_edge_us - oldest;
        reading.stalled = 1'b0;
        if (span == 0) begin
          reading.speed_rpm = SPEED_MAX;
        end else begin
          quotient = RPM_NUMERATOR / span;
          reading.speed_rpm = (quotient > 32'(SPEED_MAX)) ? SPEED_MAX : quotient[15:0];
        end
      end
      readings_due.push_back(reading);
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      foreach (edge_stamps[i]) edge_stamps[i] = '0;
      last_edge_us = '0;
      oldest_slot  = 0;
      trigger_reg  = TRIGGER_COUNT_RST;
      timeout_reg  = TIMEOUT_US_RST;
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TRIGGER_COUNT: trigger_reg = cfg_wdata[4:0];
          CFG_TIMEOUT_US:    timeout_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) apply_word(in_mon.kind, in_mon.now_us);
      if (out_mon.valid && out_mon.ready) begin
        if (readings_due.size() == 0) begin
          $error("unexpected reading: speed_rpm %0d, stalled %0b",
                 out_mon.speed_rpm, out_mon.stalled);
          fail_count++;
        end else begin
          want = readings_due.pop_front();
          if (out_mon.speed_rpm !== want.speed_rpm) begin
            $error("speed_rpm mismatch: expected %0d, actual %0d",
                   want.speed_rpm, out_mon.speed_rpm);
            fail_count++;
          end
          if (out_mon.stalled !== want.stalled) begin
            $error("stalled mismatch: expected %0b, actual %0b",
                   want.stalled, out_mon.stalled);
            fail_count++;
          end
        end
      end
    end
    pending_readings = readings_due.size();
  end

endmodule

FILE: test/tb_edge_period_tachometer.sv
// ============================================================================
// tb_edge_period_tachometer
// Drives edge and query words into the tachometer under changing window and
// timeout settings, with random gaps and output stalls; the checker beside
// the block predicts and compares every reading.
// ============================================================================
module tb_edge_period_tachometer;
  import ept_pkg::*;

  // A quiet stretch of this many cycles, with no word moving on either
  // channel, means the block has hung. The longest legal quiet stretch is the
  // deliberate output hold-off plus one division.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles allowed after the last reading before touching the registers or
  // giving the verdict; an edge word still in flight needs far less.
  localparam int SETTLE_CYCLES  = 48;
  // Length of the long output hold-off that fills the query queue.
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_WORDS   = 750;

  logic clk;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ept_in_if  in_ch();
  ept_out_if out_ch();

  int pending_readings;
  int fail_count;

  // Handshake between the stimulus and the result sink: the stimulus raises
  // it, the sink clears it when it starts the long hold-off.
  bit hold_request;
  int burst_left;

  edge_period_tachometer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tachometer_checker reading_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .pending_readings (pending_readings),
    .fail_count       (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one word and returns at the falling edge after it was taken. The
  // sender works in bursts; when a burst runs out, valid drops for a random
  // gap, which is sometimes zero so that long unbroken stretches occur.
  task automatic send_word(input logic word_kind, input logic [31:0] stamp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= word_kind;
    in_ch.now_us <= stamp;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stops offering words and waits until every predicted reading has come
  // out, then lets the block settle.
  task automatic drain_readings();
    in_ch.valid <= 1'b0;
    while (pending_readings != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Registers are only written with the block idle. The upper bits of the
  // trigger count write carry noise, which the block must ignore.
  task automatic reconfigure(input logic [4:0] trig, input logic [31:0] timeout_val);
    drain_readings();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TRIGGER_COUNT;
    cfg_wdata <= {27'($urandom()), trig};
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT_US;
    cfg_wdata <= timeout_val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result sink: ready follows a pattern picked at random from always ready
  // to mostly stalled. On request it holds off for a long stretch so that
  // the queue fills and the input stalls.
  initial begin : result_sink
    int mode;
    int span_left;
    int phase;
    out_ch.ready = 1'b0;
    mode      = 0;
    span_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (span_left == 0) begin
        mode      = $urandom_range(0, 3);
        span_left = $urandom_range(20, 200);
      end
      span_left--;
      phase++;
      case (mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ch.ready <= ($urandom_range(0, 4) == 0);
        end
        default: begin
          out_ch.ready <= ((phase % 7) < 2);
        end
      endcase
    end
  end

  // Watchdog: ends the run if no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $error("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [4:0]        trig;
    logic [31:0]       timeout_sel;
    logic [31:0]       clock_us;
    logic [31:0]       stamp;
    logic              word_kind;
    int unsigned       period_us;
    int unsigned       window;
    longint unsigned   timeout_est;
    int                words_sent;
    int                segment;
    int                forced_queries;
    int                pick;

    // Every input is known from time zero, while reset is held.
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_EDGE;
    in_ch.now_us = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_TRIGGER_COUNT;
    cfg_wdata    = '0;
    hold_request = 1'b0;
    burst_left   = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---------------------------------------------------------------------
    // Directed words, reset settings for the trigger count and the timeout.
    // ---------------------------------------------------------------------
    // A fresh ring with no edges yet: zero span saturates, not stalled.
    send_word(KIND_QUERY, 32'd0);
    // The oldest stamp is zero, so the largest timestamp is far past timeout.
    send_word(KIND_QUERY, 32'hFFFF_FFFF);
    send_word(KIND_EDGE, 32'd1000);
    send_word(KIND_EDGE, 32'd3000);
    send_word(KIND_QUERY, 32'd3500);
    // Age exactly one below and exactly at the timeout.
    send_word(KIND_QUERY, 32'd999_999);
    send_word(KIND_QUERY, 32'd1_000_000);
    send_word(KIND_EDGE, 32'd5000);
    send_word(KIND_QUERY, 32'd5100);
    // A span of 2100 microseconds gives a quotient that still fits in 16 bits.
    send_word(KIND_EDGE, 32'd5100);
    send_word(KIND_QUERY, 32'd5200);

    // Full window and zero timeout: every query reads stalled. The edges
    // also walk the position well past the next, smaller window.
    reconfigure(5'd16, 32'd0);
    send_word(KIND_EDGE, 32'hFFFF_FFFF);
    send_word(KIND_EDGE, 32'd0);
    send_word(KIND_EDGE, 32'd7);
    send_word(KIND_QUERY, 32'd8);
    send_word(KIND_EDGE, 32'd20);
    send_word(KIND_EDGE, 32'd40);
    send_word(KIND_EDGE, 32'd60);

    // Shrinking the window while the position is beyond it: the next edge
    // wraps the position to zero. Largest timeout.
    reconfigure(5'd3, 32'hFFFF_FFFF);
    send_word(KIND_EDGE, 32'd100);
    send_word(KIND_QUERY, 32'd200);

    // A trigger count of zero acts as one; a one-microsecond timeout.
    reconfigure(5'd0, 32'd1);
    send_word(KIND_EDGE, 32'd50);
    send_word(KIND_QUERY, 32'd100);
    send_word(KIND_QUERY, 32'd50);

    // A trigger count beyond the ring depth acts as the full ring.
    reconfigure(5'd31, TIMEOUT_US_RST);
    send_word(KIND_EDGE, 32'd1);
    send_word(KIND_QUERY, 32'd2);

    // ---------------------------------------------------------------------
    // Random segments. Each one picks a window, an edge period and a timeout
    // and then mostly sends a steady train of edges with queries between
    // them, so that readings cover saturation, normal speeds and stalls.
    // Dropouts jump time forward around the timeout; a few noise words with
    // arbitrary stamps break the train.
    // ---------------------------------------------------------------------
    clock_us       = $urandom();
    words_sent     = 0;
    segment        = 0;
    forced_queries = 0;
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: trig = 5'd0;
        1: trig = 5'd1;
        2: trig = 5'd16;
        3: trig = 5'd31;
        4: trig = 5'($urandom_range(17, 30));
        5: trig = TRIGGER_COUNT_RST;
        default: trig = 5'($urandom_range(1, 16));
      endcase
      window = (trig == 0) ? 1 : ((trig > 16) ? 16 : trig);

      case ($urandom_range(0, 3))
        0: period_us = $urandom_range(1, 2000);
        1: period_us = $urandom_range(2000, 50_000);
        2: period_us = $urandom_range(50_000, 3_000_000);
        default: period_us = $urandom_range(3_000_000, 150_000_000);
      endcase

      pick = $urandom_range(0, 11);
      case (pick)
        0: timeout_sel = 32'd0;
        1: timeout_sel = 32'hFFFF_FFFF;
        2: timeout_sel = TIMEOUT_US_RST;
        3: timeout_sel = 32'd1;
        default: begin
          // Somewhere around the age of the oldest stamp in a steady train.
          timeout_est = (longint'(window) * period_us * $urandom_range(2, 32)) / 8;
          if (timeout_est > 64'hFFFF_FFFF) timeout_est = 64'hFFFF_FFFF;
          if (timeout_est == 0) timeout_est = 1;
          timeout_sel = timeout_est[31:0];
        end
      endcase

      reconfigure(trig, timeout_sel);

      // Twice in the run the sink holds off for a long stretch while a run
      // of queries fills the queue and stalls the input.
      if (segment == 2 || segment == 9) begin
        hold_request   = 1'b1;
        forced_queries = 8;
      end

      repeat ($urandom_range(20, 80)) begin
        pick = $urandom_range(0, 99);
        if (forced_queries > 0) begin
          forced_queries--;
          word_kind = KIND_QUERY;
          stamp     = clock_us + $urandom_range(0, period_us);
        end else if (pick < 6) begin
          word_kind = 1'($urandom_range(0, 1));
          stamp     = $urandom();
        end else if (pick < 11) begin
          clock_us += (timeout_sel >> 1) + ($urandom() % (timeout_sel | 32'd1));
          word_kind = KIND_QUERY;
          stamp     = clock_us;
        end else if (pick < 60) begin
          clock_us += period_us - period_us / 8 + $urandom_range(0, period_us / 4);
          word_kind = KIND_EDGE;
          stamp     = clock_us;
        end else begin
          word_kind = KIND_QUERY;
          stamp     = clock_us + $urandom_range(0, period_us);
        end
        send_word(word_kind, stamp);
        words_sent++;
      end
      segment++;
    end

    // Wait for the last readings, then give the block time to show any
    // reading nobody asked for.
    drain_readings();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ept_pkg.sv
rtl/ept_if.sv
rtl/ept_front.sv
rtl/ept_queue.sv
rtl/ept_back.sv
rtl/edge_period_tachometer.sv
test/tachometer_checker.sv
test/tb_edge_period_tachometer.sv
